// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the great-circle unit.
// Needs clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GCDA_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("gcda assertion failed");
`define GCDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcda assertion failed");
`else
`define GCDA_ASSERT(lbl, cond)
`define GCDA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/gcda_pkg.sv =====
// Shared widths, constants and the Q30 multiply for the great-circle unit.
// No dependencies.
package gcda_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STAGES_DEF   = 24;

  localparam int Q_W        = 32;  // signed Q30 trig values
  localparam int BA_W       = 32;  // binary angle, 2^32 = 360 degrees
  localparam int DEG_IN_W   = 27;  // signed degree input to the converter
  localparam int CR_W       = 34;  // rotation datapath
  localparam int VEC_IN_W   = 33;  // vectoring inputs
  localparam int VEC_W      = 36;  // vectoring datapath
  localparam int SQRT_IN_W  = 62;
  localparam int SQRT_STEPS = 31;
  localparam int SQRT_RES_W = 31;

  localparam logic signed [Q_W-1:0]  Q_ONE    = 32'sd1073741824;
  localparam logic signed [CR_W-1:0] INV_GAIN = 34'sd652032874;

  // floor(2^36 / 90)
  localparam logic [29:0] RECIP_90    = 30'd763549741;
  localparam int          RECIP_SHIFT = 36;

  localparam logic [BA_W-1:0] BA_HALF    = 32'h8000_0000;
  localparam logic [BA_W-1:0] BA_QUARTER = 32'h4000_0000;
  localparam logic [BA_W-1:0] BA_3Q      = 32'hC000_0000;

  localparam logic [31:0] ATAN_TAB [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // Q30 product, rounded half up with a floor shift
  function automatic logic signed [Q_W-1:0] mulq(input logic signed [Q_W-1:0] a,
                                                 input logic signed [Q_W-1:0] b);
    logic signed [63:0] p;
    p = a * b + 64'sd536870912;
    return p[61:30];
  endfunction

endpackage

// ===== hw/rtl/gcda_deg2ba.sv =====
// Degrees (scaled by 2^F) to binary angle, rounded, five register stages.
// Divides by 90 through a reciprocal multiply with one correction. Uses gcda_pkg.
module gcda_deg2ba #(
  parameter int ANGLE_FRAC_BITS = gcda_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic signed [gcda_pkg::DEG_IN_W-1:0] deg,
  output logic                                 out_vld,
  output logic        [gcda_pkg::BA_W-1:0]     ba
);
  import gcda_pkg::*;

  localparam int K   = 30 - ANGLE_FRAC_BITS;
  localparam int MW  = DEG_IN_W - 1;
  localparam int QW  = MW - 6;
  localparam int AW  = K + 7;
  localparam int PW1 = MW + 30;
  localparam int PW2 = AW + 30;
  localparam int DW  = K + 1;

  logic [DEG_IN_W-1:0] mag;
  logic [MW-1:0]       m;

  logic            v1, v2, v3, v4, v5;
  logic            neg1, neg2, neg3, neg4;
  logic [MW-1:0]   m1;
  logic [PW1-1:0]  p1;
  logic [QW-1:0]   q2, q3, q4;
  logic [6:0]      rm2;
  logic [AW-1:0]   a3;
  logic [PW2-1:0]  p3;
  logic [DW-1:0]   qd4;

  logic [QW-1:0]   qe;
  logic [MW-1:0]   diff;
  logic [AW-1:0]   a_c;
  logic [DW-1:0]   qe2;
  logic [AW-1:0]   diff2;
  logic [63:0]     sum;
  logic [BA_W-1:0] r;

  assign mag   = deg[DEG_IN_W-1] ? DEG_IN_W'(-deg) : DEG_IN_W'(deg);
  assign m     = mag[MW-1:0];
  assign qe    = p1[PW1-1:RECIP_SHIFT];
  assign diff  = m1 - MW'(MW'(qe) * MW'(90));
  assign a_c   = (AW'(rm2) << K) + AW'(45);
  assign qe2   = p3[PW2-1:RECIP_SHIFT];
  assign diff2 = a3 - AW'(AW'(qe2) * AW'(90));
  assign sum   = (64'(q4) << K) + 64'(qd4);
  assign r     = sum[BA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
    if (en) begin
      neg1 <= deg[DEG_IN_W-1];
      m1   <= m;
      p1   <= PW1'(m) * PW1'(RECIP_90);
      neg2 <= neg1;
      // estimate is low by at most one
      if (diff >= MW'(90)) begin
        q2  <= qe + QW'(1);
        rm2 <= 7'(diff - MW'(90));
      end else begin
        q2  <= qe;
        rm2 <= 7'(diff);
      end
      neg3 <= neg2;
      q3   <= q2;
      a3   <= a_c;
      p3   <= PW2'(a_c) * PW2'(RECIP_90);
      neg4 <= neg3;
      q4   <= q3;
      qd4  <= (diff2 >= AW'(90)) ? qe2 + DW'(1) : qe2;
      ba   <= neg4 ? -r : r;
    end
  end

  assign out_vld = v5;

endmodule

// ===== hw/rtl/gcda_sincos.sv =====
// Pipelined CORDIC rotation: binary angle to Q30 cosine and sine.
// One register per stage plus entry and exit stages. Uses gcda_pkg.
module gcda_sincos #(
  parameter int CORDIC_STAGES = gcda_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic        [gcda_pkg::BA_W-1:0] ba,
  output logic                             out_vld,
  output logic signed [gcda_pkg::Q_W-1:0]  cosv,
  output logic signed [gcda_pkg::Q_W-1:0]  sinv
);
  import gcda_pkg::*;

  localparam int S = CORDIC_STAGES;

  logic [BA_W-1:0] m;

  logic signed [CR_W-1:0] x [0:S];
  logic signed [CR_W-1:0] y [0:S];
  logic signed [CR_W-1:0] z [0:S];
  logic neg  [0:S];
  logic quad [0:S];
  logic spec [0:S];
  logic rz   [0:S];
  logic vld  [0:S];

  logic signed [Q_W-1:0] c0, s0;

  function automatic logic signed [Q_W-1:0] clamp_q(input logic signed [CR_W-1:0] v);
    if (v < 0) return '0;
    else if (v > CR_W'(Q_ONE)) return Q_ONE;
    else return Q_W'(v);
  endfunction

  assign m = ba[BA_W-1] ? -ba : ba;

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_vld;
    if (en) begin
      x[0]    <= INV_GAIN;
      y[0]    <= '0;
      z[0]    <= $signed(CR_W'(m[29:0]));
      neg[0]  <= ba[BA_W-1];
      quad[0] <= m[30];
      spec[0] <= (m == BA_HALF);
      rz[0]   <= (m[29:0] == 30'd0);
    end
  end

  for (genvar i = 0; i < S; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else if (en) vld[i+1] <= vld[i];
      if (en) begin
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - $signed(CR_W'(ATAN_TAB[i]));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + $signed(CR_W'(ATAN_TAB[i]));
        end
        neg[i+1]  <= neg[i];
        quad[i+1] <= quad[i];
        spec[i+1] <= spec[i];
        rz[i+1]   <= rz[i];
      end
    end
  end

  // a zero residual is an exact axis
  assign c0 = rz[S] ? Q_ONE : clamp_q(x[S]);
  assign s0 = rz[S] ? '0    : clamp_q(y[S]);

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= vld[S];
    if (en) begin
      if (spec[S]) begin
        cosv <= -Q_ONE;
        sinv <= '0;
      end else if (!quad[S]) begin
        cosv <= c0;
        sinv <= neg[S] ? -s0 : s0;
      end else begin
        cosv <= -s0;
        sinv <= neg[S] ? -c0 : c0;
      end
    end
  end

endmodule

// ===== hw/rtl/gcda_isqrt.sv =====
// Pipelined floor square root: an entry register, then one result bit per step stage.
// Carries a tag alongside the operand. Uses gcda_pkg.
module gcda_isqrt (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_vld,
  input  logic        [gcda_pkg::SQRT_IN_W-1:0]  v,
  input  logic signed [gcda_pkg::Q_W-1:0]        tag,
  output logic                                   out_vld,
  output logic        [gcda_pkg::SQRT_RES_W-1:0] res,
  output logic signed [gcda_pkg::Q_W-1:0]        tag_o
);
  import gcda_pkg::*;

  localparam int N     = SQRT_STEPS;
  localparam int REM_W = SQRT_RES_W + 3;
  localparam int RT_W  = REM_W + 2;

  logic [SQRT_IN_W-1:0]  vr  [0:N];
  logic [REM_W-1:0]      rem [0:N];
  logic [SQRT_RES_W-1:0] rs  [0:N];
  logic signed [Q_W-1:0] tg  [0:N];
  logic                  vld [0:N];

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_vld;
    if (en) begin
      vr[0]  <= v;
      rem[0] <= '0;
      rs[0]  <= '0;
      tg[0]  <= tag;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [RT_W-1:0] rt, trial;
    assign rt    = {rem[i], vr[i][SQRT_IN_W-1 -: 2]};
    assign trial = RT_W'({rs[i], 2'b01});
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else if (en) vld[i+1] <= vld[i];
      if (en) begin
        if (rt >= trial) begin
          rem[i+1] <= REM_W'(rt - trial);
          rs[i+1]  <= {rs[i][SQRT_RES_W-2:0], 1'b1};
        end else begin
          rem[i+1] <= REM_W'(rt);
          rs[i+1]  <= {rs[i][SQRT_RES_W-2:0], 1'b0};
        end
        vr[i+1] <= vr[i] << 2;
        tg[i+1] <= tg[i];
      end
    end
  end

  assign out_vld = vld[N];
  assign res     = rs[N];
  assign tag_o   = tg[N];

endmodule

// ===== hw/rtl/gcda_vector.sv =====
// Pipelined CORDIC vectoring: atan2(y, x) as a binary angle.
// Axis cases bypass the iterations. Uses gcda_pkg.
module gcda_vector #(
  parameter int CORDIC_STAGES = gcda_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic signed [gcda_pkg::VEC_IN_W-1:0] yin,
  input  logic signed [gcda_pkg::VEC_IN_W-1:0] xin,
  output logic                                 out_vld,
  output logic        [gcda_pkg::BA_W-1:0]     ang
);
  import gcda_pkg::*;

  localparam int S = CORDIC_STAGES;

  logic signed [VEC_W-1:0] x  [0:S];
  logic signed [VEC_W-1:0] y  [0:S];
  logic [BA_W-1:0]         acc [0:S];
  logic [BA_W-1:0]         spv [0:S];
  logic                    sp  [0:S];
  logic                    vld [0:S];

  logic signed [VEC_W-1:0] xe, ye, x0, y0;
  logic [BA_W-1:0]         acc0, spv0;
  logic                    sp0;

  assign xe = VEC_W'(xin);
  assign ye = VEC_W'(yin);

  always_comb begin
    sp0  = 1'b0;
    spv0 = '0;
    if (yin == 0) begin
      sp0  = 1'b1;
      spv0 = (xin >= 0) ? '0 : BA_HALF;
    end else if (xin == 0) begin
      sp0  = 1'b1;
      spv0 = (yin > 0) ? BA_QUARTER : BA_3Q;
    end
    // left half-plane: turn by 180 degrees first
    if (xin < 0) begin
      x0   = -xe;
      y0   = -ye;
      acc0 = BA_HALF;
    end else begin
      x0   = xe;
      y0   = ye;
      acc0 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_vld;
    if (en) begin
      x[0]   <= x0;
      y[0]   <= y0;
      acc[0] <= acc0;
      sp[0]  <= sp0;
      spv[0] <= spv0;
    end
  end

  for (genvar i = 0; i < S; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else if (en) vld[i+1] <= vld[i];
      if (en) begin
        if (y[i] > 0) begin
          x[i+1]   <= x[i] + (y[i] >>> i);
          y[i+1]   <= y[i] - (x[i] >>> i);
          acc[i+1] <= acc[i] + ATAN_TAB[i];
        end else begin
          x[i+1]   <= x[i] - (y[i] >>> i);
          y[i+1]   <= y[i] + (x[i] >>> i);
          acc[i+1] <= acc[i] - ATAN_TAB[i];
        end
        sp[i+1]  <= sp[i];
        spv[i+1] <= spv[i];
      end
    end
  end

  assign out_vld = vld[S];
  assign ang     = sp[S] ? spv[S] : acc[S];

endmodule

// ===== hw/rtl/great_circle_distance_azimuth_unit.sv =====
// Great-circle distance and azimuth between two points on a unit sphere.
// Input channel (in_valid/in_stall) carries lat_a, lon_a, lat_b, lon_b,
// signed degrees scaled by 2^ANGLE_FRAC_BITS. Output channel
// (out_valid/out_stall) carries arc_distance (0..180 degrees) and bearing
// (azimuth clockwise from north, [0,360)), same scale. One result per item.
// Throughput: one item per cycle while in_stall is low. The path from accept
// to out_valid runs through two CORDIC rotation/vectoring pipelines in
// series and the 32-stage square root.
// Every stage carries a valid bit; the whole pipeline advances unless a
// result sits in the output register while out_stall is high, so in_stall
// is high exactly then. Nothing is dropped or repeated under stall.
// Synchronous reset clears all valid bits; no clearing pass is needed and
// the block accepts items in the first cycle after reset.
// Uses gcda_pkg, gcda_deg2ba, gcda_sincos, gcda_isqrt, gcda_vector.
`include "assert_macros.svh"
module great_circle_distance_azimuth_unit #(
  parameter int ANGLE_FRAC_BITS = gcda_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = gcda_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] lat_a,
  input  logic signed [25:0] lon_a,
  input  logic signed [23:0] lat_b,
  input  logic signed [25:0] lon_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [23:0] arc_distance,
  output logic        [24:0] bearing
);
  import gcda_pkg::*;

  localparam int F     = ANGLE_FRAC_BITS;
  localparam int DEG_W = F + 10;
  localparam int BW    = F + 39;
  localparam int D     = SQRT_STEPS + 4;
  localparam logic [DEG_W-1:0] DIST_MAX = DEG_W'(180) << F;
  localparam logic [DEG_W-1:0] FULL     = DEG_W'(360) << F;

  function automatic logic [DEG_W-1:0] ba_to_deg(input logic [BA_W-1:0] a);
    logic [37:0]   p;
    logic [BW-1:0] w;
    p = 38'(a) * 38'd45;
    w = (BW'(p) << F) + BW'(2**28);
    return w[BW-1:29];
  endfunction

  logic en;

  // input stage
  logic                       vi;
  logic signed [DEG_IN_W-1:0] la_i, lb_i, dl_i;

  // angle conversion and trig
  logic            vld_da, vld_db, vld_dd;
  logic [BA_W-1:0] ba_la, ba_lb, ba_dl;
  logic            vld_sa, vld_sb, vld_sd;
  logic signed [Q_W-1:0] ca, sa, cb, sb, cd, sd;
  logic signed [Q_W-1:0] ca_abs, cb_abs;

  // products
  logic                  v_p1, v_p2, v_p3, v_p4, v_p5;
  logic signed [Q_W-1:0] p_cacb, p_sasb, p_sacd, p_y, p_casb, cd1, cb1;
  logic signed [Q_W:0]   t_p2, x_p2;
  logic signed [Q_W-1:0] y_p2;
  logic signed [Q_W-1:0] t_p3, t_p4, t_p5;
  logic signed [63:0]    t_sq;
  logic [60:0]           tsq_p4;
  logic [SQRT_IN_W-1:0]  v_sq;

  // square root and vectoring
  logic                   sq_vld;
  logic [SQRT_RES_W-1:0]  sq_res;
  logic signed [Q_W-1:0]  sq_tag;
  logic                   dv_vld, bv_vld;
  logic [BA_W-1:0]        dba_raw, bba_raw;
  logic [BA_W-1:0]        bdly [0:D-1];

  // finish
  logic             vld_f1, vld_f2;
  logic [BA_W-1:0]  dba_f1, bba_f1;
  logic [DEG_W-1:0] dist_f2, brg_f2, dist_o, brg_o;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) vi <= 1'b0;
    else if (en) vi <= in_valid;
    if (en) begin
      la_i <= DEG_IN_W'(lat_a);
      lb_i <= DEG_IN_W'(lat_b);
      dl_i <= DEG_IN_W'(lon_b) - DEG_IN_W'(lon_a);
    end
  end

  gcda_deg2ba #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_d2b_a (
    .clk(clk), .rst(rst), .en(en), .in_vld(vi), .deg(la_i),
    .out_vld(vld_da), .ba(ba_la));
  gcda_deg2ba #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_d2b_b (
    .clk(clk), .rst(rst), .en(en), .in_vld(vi), .deg(lb_i),
    .out_vld(vld_db), .ba(ba_lb));
  gcda_deg2ba #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_d2b_d (
    .clk(clk), .rst(rst), .en(en), .in_vld(vi), .deg(dl_i),
    .out_vld(vld_dd), .ba(ba_dl));

  gcda_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_a (
    .clk(clk), .rst(rst), .en(en), .in_vld(vld_da), .ba(ba_la),
    .out_vld(vld_sa), .cosv(ca), .sinv(sa));
  gcda_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_b (
    .clk(clk), .rst(rst), .en(en), .in_vld(vld_db), .ba(ba_lb),
    .out_vld(vld_sb), .cosv(cb), .sinv(sb));
  gcda_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_d (
    .clk(clk), .rst(rst), .en(en), .in_vld(vld_dd), .ba(ba_dl),
    .out_vld(vld_sd), .cosv(cd), .sinv(sd));

  // latitudes past the pole fold back onto the sphere
  assign ca_abs = (ca < 0) ? -ca : ca;
  assign cb_abs = (cb < 0) ? -cb : cb;
  assign t_sq   = t_p4 * t_p4;
  assign v_sq   = (SQRT_IN_W'(1) << 60) - SQRT_IN_W'(tsq_p4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p1 <= 1'b0;
      v_p2 <= 1'b0;
      v_p3 <= 1'b0;
      v_p4 <= 1'b0;
      v_p5 <= 1'b0;
    end else if (en) begin
      v_p1 <= vld_sd;
      v_p2 <= v_p1;
      v_p3 <= v_p2;
      v_p4 <= v_p3;
      v_p5 <= v_p4;
    end
    if (en) begin
      p_cacb <= mulq(ca_abs, cb_abs);
      p_sasb <= mulq(sa, sb);
      p_sacd <= mulq(sa, cd);
      p_y    <= mulq(sd, cb_abs);
      p_casb <= mulq(ca_abs, sb);
      cd1    <= cd;
      cb1    <= cb_abs;
      t_p2   <= (Q_W+1)'(mulq(p_cacb, cd1)) + (Q_W+1)'(p_sasb);
      x_p2   <= (Q_W+1)'(p_casb) - (Q_W+1)'(mulq(p_sacd, cb1));
      y_p2   <= p_y;
      // saturate the acos argument
      if (t_p2 > (Q_W+1)'(Q_ONE)) t_p3 <= Q_ONE;
      else if (t_p2 < -((Q_W+1)'(Q_ONE))) t_p3 <= -Q_ONE;
      else t_p3 <= Q_W'(t_p2);
      tsq_p4 <= t_sq[60:0];
      t_p4   <= t_p3;
      t_p5   <= t_p4;
    end
  end

  // sine of the distance rides in the root, cosine in the tag
  gcda_isqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_vld(v_p5), .v(v_sq), .tag(t_p5),
    .out_vld(sq_vld), .res(sq_res), .tag_o(sq_tag));

  gcda_vector #(.CORDIC_STAGES(CORDIC_STAGES)) u_vec_dist (
    .clk(clk), .rst(rst), .en(en), .in_vld(sq_vld),
    .yin($signed(VEC_IN_W'(sq_res))), .xin(VEC_IN_W'(sq_tag)),
    .out_vld(dv_vld), .ang(dba_raw));

  gcda_vector #(.CORDIC_STAGES(CORDIC_STAGES)) u_vec_brg (
    .clk(clk), .rst(rst), .en(en), .in_vld(v_p2),
    .yin(VEC_IN_W'(y_p2)), .xin(x_p2),
    .out_vld(bv_vld), .ang(bba_raw));

  // hold the bearing until the distance path catches up
  always_ff @(posedge clk) begin
    if (en) begin
      bdly[0] <= bba_raw;
      for (int k = 1; k < D; k++) bdly[k] <= bdly[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_f1    <= 1'b0;
      vld_f2    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_f1    <= dv_vld;
      vld_f2    <= vld_f1;
      out_valid <= vld_f2;
    end
    if (en) begin
      // vectoring overshoot past 180 degrees
      if (dba_raw > BA_HALF) dba_f1 <= (dba_raw >= BA_3Q) ? '0 : BA_HALF;
      else dba_f1 <= dba_raw;
      bba_f1  <= bdly[D-1];
      dist_f2 <= ba_to_deg(dba_f1);
      brg_f2  <= ba_to_deg(bba_f1);
      dist_o  <= dist_f2;
      brg_o   <= (brg_f2 >= FULL) ? brg_f2 - FULL : brg_f2;
    end
  end

  assign arc_distance = 24'(dist_o);
  assign bearing      = 25'(brg_o);

  `GCDA_ASSERT(a_trig_aligned, (vld_sa == vld_sd) && (vld_sb == vld_sd))
  `GCDA_ASSERT(a_dist_range, !vld_f2 || (dist_f2 <= DIST_MAX))
  `GCDA_ASSERT(a_brg_wrapped, !out_valid || (brg_o < FULL))
  `GCDA_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_f2) && $stable(v_p5) && $stable(bv_vld))

endmodule
